// ===== design/text_grid_cursor_editor_core_defines.svh =====
// Assertion macros for the text grid cursor editor core.
// Included by the RTL files that carry checks; expects clk_i and rst_ni in scope.
`ifndef TEXT_GRID_CURSOR_EDITOR_CORE_DEFINES_SVH
`define TEXT_GRID_CURSOR_EDITOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TGCE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tgce: property failed");
`define TGCE_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("tgce: forbidden condition seen");
`else
`define TGCE_ASSERT(name, prop)
`define TGCE_NEVER(name, expr)
`endif
`endif

// ===== design/tgce_pkg.sv =====
// Shared types and constants for the text grid cursor editor core.
// No dependencies; used by tgce_ctrl, tgce_dp and the top level.
`default_nettype none

package tgce_pkg;

  localparam int KIND_W     = 4;
  localparam int IN_CHAR_W  = 8;
  localparam int CHAR_W     = 7;
  localparam int ROW_OUT_W  = 5;
  localparam int COL_OUT_W  = 6;
  localparam int COLOR_W    = 3;
  localparam int BLINK_W    = 24;
  localparam int ROWS_CFG_W = 6;
  localparam int COLS_CFG_W = 7;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int OUT_DATA_W = 40;

  localparam logic [CHAR_W-1:0]     SPACE_CH  = 7'h20;
  localparam logic [IN_CHAR_W-1:0]  PRINT_LO  = 8'h20;
  localparam logic [IN_CHAR_W-1:0]  PRINT_HI  = 8'h7E;
  localparam logic [IN_CHAR_W-1:0]  LOWER_LO  = 8'h61;
  localparam logic [IN_CHAR_W-1:0]  LOWER_HI  = 8'h7A;
  localparam logic [IN_CHAR_W-1:0]  CASE_FOLD = 8'h20;

  localparam logic [ROWS_CFG_W-1:0] RST_ROWS  = 6'd32;
  localparam logic [COLS_CFG_W-1:0] RST_COLS  = 7'd64;
  localparam logic [BLINK_W-1:0]    RST_BLINK = 24'd500;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK      = 4'd0,
    KIND_CHAR      = 4'd1,
    KIND_RETURN    = 4'd2,
    KIND_BACKSPACE = 4'd3,
    KIND_HOME      = 4'd4,
    KIND_END       = 4'd5,
    KIND_PGUP      = 4'd6,
    KIND_PGDN      = 4'd7,
    KIND_LEFT      = 4'd8,
    KIND_RIGHT     = 4'd9,
    KIND_UP        = 4'd10,
    KIND_DOWN      = 4'd11,
    KIND_CLEAR     = 4'd12,
    KIND_COLOR     = 4'd13,
    KIND_OTHER     = 4'd14
  } kind_e;

  typedef enum logic [1:0] {
    REG_ROWS  = 2'd0,
    REG_COLS  = 2'd1,
    REG_BLINK = 2'd2
  } reg_idx_e;

  // Datapath commands, one per cycle from the controller.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_EXEC,
    CMD_CLR,
    CMD_SCAN_CHK,
    CMD_BS_WR,
    CMD_FINISH
  } cmd_e;

  typedef struct packed {
    logic go_clear;
    logic go_scan;
    logic scan_more;
    logic bs_pending;
    logic clr_last;
    logic out_free;
  } status_t;

  // Result word, lowest field last.
  typedef struct packed {
    logic                 grid_cleared;
    logic [CHAR_W-1:0]    cell_char;
    logic [COL_OUT_W-1:0] cell_col;
    logic [ROW_OUT_W-1:0] cell_row;
    logic                 cell_written;
    logic [COLOR_W-1:0]   color_index;
    logic                 cursor_visible;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [ROW_OUT_W-1:0] cursor_row;
  } out_t;

endpackage

`default_nettype wire

// ===== design/tgce_ctrl.sv =====
// Sequencer for the text grid cursor editor: issues one datapath command a cycle.
// Depends on tgce_pkg (cmd_e, status_t).
`default_nettype none

module tgce_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire tgce_pkg::status_t status_i,
  output tgce_pkg::cmd_e         cmd_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_BS_WR,
    ST_FINISH
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    case (state_q)
      ST_INIT:     cmd_o = tgce_pkg::CMD_CLR;
      ST_IDLE:     cmd_o = in_valid_i ? tgce_pkg::CMD_LATCH : tgce_pkg::CMD_NONE;
      ST_EXEC:     cmd_o = tgce_pkg::CMD_EXEC;
      ST_CLR:      cmd_o = tgce_pkg::CMD_CLR;
      ST_SCAN_RD:  cmd_o = tgce_pkg::CMD_NONE;
      ST_SCAN_CHK: cmd_o = tgce_pkg::CMD_SCAN_CHK;
      ST_BS_WR:    cmd_o = tgce_pkg::CMD_BS_WR;
      ST_FINISH:   cmd_o = status_i.out_free ? tgce_pkg::CMD_FINISH : tgce_pkg::CMD_NONE;
      default:     cmd_o = tgce_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      case (state_q)
        ST_INIT: begin
          if (status_i.clr_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (status_i.go_clear) state_q <= ST_CLR;
          else if (status_i.go_scan) state_q <= ST_SCAN_RD;
          else state_q <= ST_FINISH;
        end
        ST_CLR: begin
          if (status_i.clr_last) state_q <= ST_FINISH;
        end
        ST_SCAN_RD: begin
          state_q <= ST_SCAN_CHK;
        end
        ST_SCAN_CHK: begin
          if (status_i.scan_more) state_q <= ST_SCAN_RD;
          else if (status_i.bs_pending) state_q <= ST_BS_WR;
          else state_q <= ST_FINISH;
        end
        ST_BS_WR: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (status_i.out_free) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/tgce_dp.sv =====
// Datapath of the text grid cursor editor: cursor, color, blink, character store,
// end-of-line scan and the result register. Depends on tgce_pkg and the defines header.
`default_nettype none
`include "text_grid_cursor_editor_core_defines.svh"

module tgce_dp #(
  parameter int MAX_ROWS    = 32,
  parameter int MAX_COLS    = 64,
  parameter int COLOR_COUNT = 5
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire tgce_pkg::cmd_e                    cmd_i,
  output tgce_pkg::status_t                      status_o,
  input  wire logic [tgce_pkg::KIND_W-1:0]       in_kind_i,
  input  wire logic [tgce_pkg::IN_CHAR_W-1:0]    in_char_i,
  input  wire logic [tgce_pkg::ROWS_CFG_W-1:0]   rows_cfg_i,
  input  wire logic [tgce_pkg::COLS_CFG_W-1:0]   cols_cfg_i,
  input  wire logic [tgce_pkg::BLINK_W-1:0]      blink_cfg_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output tgce_pkg::out_t                         out_data_o
);

  localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW        = $clog2(MAX_COLS);
  localparam int MEM_DEPTH = MAX_ROWS * (2 ** CW);
  localparam int AW        = $clog2(MEM_DEPTH);

  // control state
  logic [RW-1:0]                   cur_row_q;
  logic [CW-1:0]                   cur_col_q;
  logic                            cursor_on_q;
  logic [tgce_pkg::COLOR_W-1:0]    color_q;
  logic [tgce_pkg::BLINK_W-1:0]    blink_q;
  logic [AW-1:0]                   clr_addr_q;
  logic                            out_valid_q;

  // payload
  tgce_pkg::kind_e                 kind_q;
  logic [tgce_pkg::IN_CHAR_W-1:0]  char_q;
  logic                            cell_wr_q;
  logic [RW-1:0]                   cell_row_q;
  logic [CW-1:0]                   cell_col_q;
  logic [tgce_pkg::CHAR_W-1:0]     cell_ch_q;
  logic                            cleared_q;
  logic [tgce_pkg::CHAR_W-1:0]     rdata_q;
  tgce_pkg::out_t                  out_q;
  logic [tgce_pkg::CHAR_W-1:0]     mem [MEM_DEPTH];

  logic [RW-1:0]                   rows_m1;
  logic [CW-1:0]                   cols_m1;
  logic [RW-1:0]                   row_s;
  logic [CW-1:0]                   col_s;
  logic                            printable;
  logic [tgce_pkg::IN_CHAR_W-1:0]  folded;
  logic                            go_scan;
  logic                            we;
  logic [RW-1:0]                   wrow;
  logic [CW-1:0]                   wcol;
  logic [tgce_pkg::CHAR_W-1:0]     wdata;
  logic [AW-1:0]                   waddr;
  logic [AW-1:0]                   raddr;
  logic                            clr_last;
  logic                            scan_more;
  logic [tgce_pkg::BLINK_W-1:0]    blink_next;
  logic [tgce_pkg::BLINK_W-1:0]    period;
  logic                            blink_flip;
  logic [tgce_pkg::COLOR_W-1:0]    color_next;

  // Active grid limits, zero counts as one and oversize saturates.
  always_comb begin
    if (rows_cfg_i == '0) rows_m1 = '0;
    else if (int'(rows_cfg_i) > MAX_ROWS) rows_m1 = RW'(MAX_ROWS - 1);
    else rows_m1 = RW'(rows_cfg_i - 6'd1);
    if (cols_cfg_i == '0) cols_m1 = '0;
    else if (int'(cols_cfg_i) > MAX_COLS) cols_m1 = CW'(MAX_COLS - 1);
    else cols_m1 = CW'(cols_cfg_i - 7'd1);
  end

  // Cursor pulled back into the grid if the registers shrank.
  assign row_s = (cur_row_q > rows_m1) ? rows_m1 : cur_row_q;
  assign col_s = (cur_col_q > cols_m1) ? cols_m1 : cur_col_q;

  assign printable = (char_q >= tgce_pkg::PRINT_LO) && (char_q <= tgce_pkg::PRINT_HI);
  assign folded    = ((char_q >= tgce_pkg::LOWER_LO) && (char_q <= tgce_pkg::LOWER_HI)) ?
                     (char_q - tgce_pkg::CASE_FOLD) : char_q;

  // End scans, as does Backspace at column 0 below the top row (it backs up a line).
  assign go_scan = (kind_q == tgce_pkg::KIND_END) ||
                   ((kind_q == tgce_pkg::KIND_BACKSPACE) && (col_s == '0) && (row_s != '0));

  assign period     = (blink_cfg_i == '0) ? tgce_pkg::BLINK_W'(1) : blink_cfg_i;
  assign blink_next = blink_q + tgce_pkg::BLINK_W'(1);
  assign blink_flip = (blink_next >= period) || (blink_next == '0);
  assign color_next = (color_q >= tgce_pkg::COLOR_W'(COLOR_COUNT - 1)) ?
                      '0 : color_q + tgce_pkg::COLOR_W'(1);

  // Store write port.
  always_comb begin
    we    = 1'b0;
    wrow  = row_s;
    wcol  = col_s;
    wdata = tgce_pkg::SPACE_CH;
    case (cmd_i)
      tgce_pkg::CMD_CLR: begin
        we = 1'b1;
      end
      tgce_pkg::CMD_EXEC: begin
        if (kind_q == tgce_pkg::KIND_CHAR && printable) begin
          we    = 1'b1;
          wdata = tgce_pkg::CHAR_W'(folded);
        end else if (kind_q == tgce_pkg::KIND_BACKSPACE && !go_scan) begin
          we = 1'b1;
          if (col_s != '0) wcol = col_s - CW'(1);
        end
      end
      tgce_pkg::CMD_BS_WR: begin
        we   = 1'b1;
        wrow = cur_row_q;
        wcol = cur_col_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign waddr     = (cmd_i == tgce_pkg::CMD_CLR) ? clr_addr_q : AW'({wrow, wcol});
  assign raddr     = AW'({cur_row_q, cur_col_q});
  assign clr_last  = (clr_addr_q == AW'(MEM_DEPTH - 1));
  assign scan_more = (rdata_q == tgce_pkg::SPACE_CH) && (cur_col_q != '0);

  assign status_o.go_clear   = (kind_q == tgce_pkg::KIND_CLEAR);
  assign status_o.go_scan    = go_scan;
  assign status_o.scan_more  = scan_more;
  assign status_o.bs_pending = (kind_q == tgce_pkg::KIND_BACKSPACE);
  assign status_o.clr_last   = clr_last;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      cursor_on_q <= 1'b1;
      color_q     <= '0;
      blink_q     <= '0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i)
        tgce_pkg::CMD_EXEC: begin
          cur_row_q <= row_s;
          cur_col_q <= col_s;
          case (kind_q)
            tgce_pkg::KIND_TICK: begin
              if (blink_flip) begin
                blink_q     <= '0;
                cursor_on_q <= !cursor_on_q;
              end else begin
                blink_q <= blink_next;
              end
            end
            tgce_pkg::KIND_CHAR: begin
              if (printable) begin
                if (col_s < cols_m1) begin
                  cur_col_q <= col_s + CW'(1);
                end else if (row_s < rows_m1) begin
                  cur_col_q <= '0;
                  cur_row_q <= row_s + RW'(1);
                end
              end
            end
            tgce_pkg::KIND_RETURN: begin
              if (row_s < rows_m1) begin
                cur_row_q <= row_s + RW'(1);
                cur_col_q <= '0;
              end
            end
            tgce_pkg::KIND_BACKSPACE: begin
              if (col_s != '0) begin
                cur_col_q <= col_s - CW'(1);
              end else if (row_s != '0) begin
                cur_row_q <= row_s - RW'(1);
                cur_col_q <= cols_m1;
              end
            end
            tgce_pkg::KIND_HOME:  cur_col_q <= '0;
            tgce_pkg::KIND_END:   cur_col_q <= cols_m1;
            tgce_pkg::KIND_PGUP:  cur_row_q <= '0;
            tgce_pkg::KIND_PGDN:  cur_row_q <= rows_m1;
            tgce_pkg::KIND_LEFT: begin
              if (col_s != '0) cur_col_q <= col_s - CW'(1);
            end
            tgce_pkg::KIND_RIGHT: begin
              if (col_s < cols_m1) cur_col_q <= col_s + CW'(1);
            end
            tgce_pkg::KIND_UP: begin
              if (row_s != '0) cur_row_q <= row_s - RW'(1);
            end
            tgce_pkg::KIND_DOWN: begin
              if (row_s < rows_m1) cur_row_q <= row_s + RW'(1);
            end
            tgce_pkg::KIND_CLEAR: begin
              cur_row_q <= '0;
              cur_col_q <= '0;
              color_q   <= '0;
            end
            tgce_pkg::KIND_COLOR: color_q <= color_next;
            default: begin
              cur_row_q <= row_s;
            end
          endcase
          // any key restarts the blink with the cursor shown
          if (kind_q != tgce_pkg::KIND_TICK) begin
            cursor_on_q <= 1'b1;
            blink_q     <= '0;
          end
        end
        tgce_pkg::CMD_CLR: begin
          clr_addr_q <= clr_last ? '0 : clr_addr_q + AW'(1);
        end
        tgce_pkg::CMD_SCAN_CHK: begin
          if (scan_more) begin
            cur_col_q <= cur_col_q - CW'(1);
          end else if (rdata_q != tgce_pkg::SPACE_CH && cur_col_q < cols_m1) begin
            cur_col_q <= cur_col_q + CW'(1);
          end
        end
        default: begin
          clr_addr_q <= clr_addr_q;
        end
      endcase

      if (cmd_i == tgce_pkg::CMD_FINISH) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];

    if (cmd_i == tgce_pkg::CMD_LATCH) begin
      kind_q <= tgce_pkg::kind_e'(in_kind_i);
      char_q <= in_char_i;
    end

    if (cmd_i == tgce_pkg::CMD_EXEC || cmd_i == tgce_pkg::CMD_BS_WR) begin
      cell_wr_q  <= we;
      cell_row_q <= we ? wrow : '0;
      cell_col_q <= we ? wcol : '0;
      cell_ch_q  <= we ? wdata : '0;
    end
    if (cmd_i == tgce_pkg::CMD_EXEC) cleared_q <= (kind_q == tgce_pkg::KIND_CLEAR);

    if (cmd_i == tgce_pkg::CMD_FINISH) begin
      out_q.cursor_row     <= tgce_pkg::ROW_OUT_W'(cur_row_q);
      out_q.cursor_col     <= tgce_pkg::COL_OUT_W'(cur_col_q);
      out_q.cursor_visible <= cursor_on_q;
      out_q.color_index    <= color_q;
      out_q.cell_written   <= cell_wr_q;
      out_q.cell_row       <= tgce_pkg::ROW_OUT_W'(cell_row_q);
      out_q.cell_col       <= tgce_pkg::COL_OUT_W'(cell_col_q);
      out_q.cell_char      <= cell_ch_q;
      out_q.grid_cleared   <= cleared_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TGCE_ASSERT(a_finish_slot_free,
               (cmd_i == tgce_pkg::CMD_FINISH) |-> (!out_valid_q || out_ready_i))
  `TGCE_ASSERT(a_sweep_wraps, (cmd_i == tgce_pkg::CMD_CLR && clr_last) |=> (clr_addr_q == '0))
  `TGCE_ASSERT(a_clear_homes,
               (cmd_i == tgce_pkg::CMD_FINISH && cleared_q) |-> (cur_row_q == '0 && cur_col_q == '0))
  `TGCE_NEVER(a_row_in_store, cur_row_q > RW'(MAX_ROWS - 1))

endmodule

`default_nettype wire

// ===== design/text_grid_cursor_editor_core.sv =====
// Text grid cursor editor core: one result word per input word.
// Most keys take the execute and finish states; finish waits while the output is held.
// End adds a read and a check state per column scanned, Backspace across a line the same
// plus a store write; Clear writes every store cell (MAX_ROWS * 2**clog2(MAX_COLS), 2048 by
// default). A new word is taken once the previous result is registered. After reset the
// store is swept to spaces for that cell count with s_axis_tready low; config works at once.
`default_nettype none

module text_grid_cursor_editor_core #(
  parameter int MAX_ROWS    = 32,
  parameter int MAX_COLS    = 64,
  parameter int COLOR_COUNT = 5
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // stream in
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [tgce_pkg::IN_CHAR_W-1:0]      s_axis_tdata,  // [7:0] char_code
  input  wire logic [tgce_pkg::KIND_W-1:0]         s_axis_tuser,  // [3:0] kind
  // stream out
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [4:0] cursor_row, [10:5] cursor_col, [11] cursor_visible, [14:12] color_index,
  // [15] cell_written, [20:16] cell_row, [26:21] cell_col, [33:27] cell_char,
  // [34] grid_cleared, [39:35] zero
  output logic [tgce_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  // configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [tgce_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [tgce_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tgce_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                     pready
);

  logic [tgce_pkg::ROWS_CFG_W-1:0] rows_q;
  logic [tgce_pkg::COLS_CFG_W-1:0] cols_q;
  logic [tgce_pkg::BLINK_W-1:0]    blink_q;
  tgce_pkg::reg_idx_e              reg_idx;
  logic                            cfg_wr;
  tgce_pkg::cmd_e                  cmd;
  tgce_pkg::status_t               status;
  tgce_pkg::out_t                  out_data;

  assign pready  = 1'b1;
  assign reg_idx = tgce_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= tgce_pkg::RST_ROWS;
      cols_q  <= tgce_pkg::RST_COLS;
      blink_q <= tgce_pkg::RST_BLINK;
    end else if (cfg_wr) begin
      case (reg_idx)
        tgce_pkg::REG_ROWS:  rows_q  <= pwdata[tgce_pkg::ROWS_CFG_W-1:0];
        tgce_pkg::REG_COLS:  cols_q  <= pwdata[tgce_pkg::COLS_CFG_W-1:0];
        tgce_pkg::REG_BLINK: blink_q <= pwdata[tgce_pkg::BLINK_W-1:0];
        default:             rows_q  <= rows_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tgce_pkg::REG_ROWS:  prdata = tgce_pkg::APB_DATA_W'(rows_q);
      tgce_pkg::REG_COLS:  prdata = tgce_pkg::APB_DATA_W'(cols_q);
      tgce_pkg::REG_BLINK: prdata = tgce_pkg::APB_DATA_W'(blink_q);
      default:             prdata = '0;
    endcase
  end

  tgce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tgce_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .COLOR_COUNT (COLOR_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_kind_i   (s_axis_tuser),
    .in_char_i   (s_axis_tdata),
    .rows_cfg_i  (rows_q),
    .cols_cfg_i  (cols_q),
    .blink_cfg_i (blink_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata = tgce_pkg::OUT_DATA_W'(out_data);

endmodule

`default_nettype wire
